// File: src/prqs_pkg.sv
// Package for the priority ready queue scheduler: codes, sequencer states,
// result record and default sizes. No dependencies; every other file imports it.
package prqs_pkg;

    localparam int PRQS_NUM_TASKS      = 16;
    localparam int PRQS_NUM_PRIORITIES = 4;

    localparam int ACTION_W   = 2;
    localparam int TASK_ID_W  = 4;
    localparam int PRIORITY_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_YIELD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_POP,
        ST_LINK,
        ST_REQUEUE,
        ST_NOP
    } prqs_state_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] active_task;
        logic                 running_valid;
        logic                 switched;
        logic                 status;
    } prqs_res_t;

endpackage

// File: src/prqs_ram.sv
// Single write port, single read port memory with registered read data.
// Used for the task link list and the per-task priority table; imports prqs_pkg.
module prqs_ram
    import prqs_pkg::*;
#(
    parameter int DEPTH = PRQS_NUM_TASKS,
    parameter int WIDTH = TASK_ID_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/prqs_core.sv
// Scheduler sequencer: ready queue heads and tails, live bits, running task,
// and the state machine that drives the link and priority memories (prqs_ram).
module prqs_core
    import prqs_pkg::*;
#(
    parameter int NUM_TASKS      = PRQS_NUM_TASKS,
    parameter int NUM_PRIORITIES = PRQS_NUM_PRIORITIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ACTION_W-1:0]   action,
    input  logic [TASK_ID_W-1:0]  task_id,
    input  logic [PRIORITY_W-1:0] priority_req,
    input  logic                  out_free,
    output logic                  res_valid,
    output prqs_res_t             res
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

    prqs_state_t state_reg, state_next;

    logic [TASK_ID_W-1:0]  id_reg;
    logic [PRIORITY_W-1:0] pri_reg;
    logic                  was_running_reg;
    logic [PW-1:0]         pop_q_reg;
    logic [TW-1:0]         pop_task_reg;
    logic [TW-1:0]         head_reg [NUM_PRIORITIES];
    logic [TW-1:0]         tail_reg [NUM_PRIORITIES];
    logic [NUM_PRIORITIES-1:0] nonempty_reg;
    logic [NUM_TASKS-1:0]  live_reg;
    logic [TW-1:0]         cur_task_reg;
    logic                  cur_valid_reg;

    logic [TW-1:0] id_idx;
    logic          create_ok;
    logic [PW-1:0] pri_cl;
    logic          any_ready;
    logic [PW-1:0] enc_q;
    logic [PW-1:0] q_idx;
    logic [TW-1:0] q_head;
    logic [TW-1:0] q_tail;
    logic          q_ne;

    logic          link_we, link_re;
    logic [TW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
    logic          prio_we, prio_re;
    logic [TW-1:0] prio_waddr, prio_raddr;
    logic [PW-1:0] prio_wdata, prio_rdata;

    prqs_ram #(.DEPTH(NUM_TASKS), .WIDTH(TW)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    prqs_ram #(.DEPTH(NUM_TASKS), .WIDTH(PW)) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (prio_waddr),
        .wdata (prio_wdata),
        .re    (prio_re),
        .raddr (prio_raddr),
        .rdata (prio_rdata)
    );

    // Decode of the latched create request.
    assign id_idx    = TW'(id_reg);
    assign create_ok = (32'(id_reg) < 32'(NUM_TASKS)) && !live_reg[id_idx];
    assign pri_cl    = (32'(pri_reg) >= 32'(NUM_PRIORITIES)) ? PW'(NUM_PRIORITIES - 1)
                                                              : PW'(pri_reg);

    // Highest ready level: lowest index with a non-empty queue.
    always_comb
    begin
        any_ready = 1'b0;
        enc_q     = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                any_ready = 1'b1;
                enc_q     = PW'(i);
            end
        end
    end

    // One queue is looked at per cycle; the state picks which one.
    always_comb
    begin
        unique case (state_reg)
            ST_CREATE:  q_idx = pri_cl;
            ST_LINK:    q_idx = pop_q_reg;
            ST_REQUEUE: q_idx = prio_rdata;
            default:    q_idx = enc_q;
        endcase
    end

    assign q_head = head_reg[q_idx];
    assign q_tail = tail_reg[q_idx];
    assign q_ne   = nonempty_reg[q_idx];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action) inside
                        ACT_CREATE:             state_next = ST_CREATE;
                        ACT_YIELD, ACT_FINISH:  state_next = ST_POP;
                        default:                state_next = ST_NOP;
                    endcase
                end
            end
            ST_CREATE, ST_REQUEUE, ST_NOP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (!any_ready)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (q_head == q_tail)
                begin
                    state_next = ST_REQUEUE;
                end
                else
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_REQUEUE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        link_we    = 1'b0;
        link_waddr = q_tail;
        link_wdata = id_idx;
        link_re    = 1'b0;
        link_raddr = q_head;
        prio_we    = 1'b0;
        prio_waddr = id_idx;
        prio_wdata = pri_cl;
        prio_re    = 1'b0;
        prio_raddr = cur_task_reg;
        res_valid  = 1'b0;
        res.active_task   = cur_valid_reg ? TASK_ID_W'(cur_task_reg) : '0;
        res.running_valid = cur_valid_reg;
        res.switched      = 1'b0;
        res.status        = STATUS_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CREATE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    res.status = create_ok ? STATUS_OK : STATUS_REFUSED;
                    prio_we    = create_ok;
                    link_we    = create_ok && q_ne;
                end
            end
            ST_POP:
            begin
                link_re = any_ready;
                prio_re = any_ready;
                if (!any_ready && out_free)
                begin
                    res_valid    = 1'b1;
                    res.switched = was_running_reg;
                end
            end
            ST_REQUEUE:
            begin
                if (out_free)
                begin
                    res_valid         = 1'b1;
                    res.active_task   = TASK_ID_W'(pop_task_reg);
                    res.running_valid = 1'b1;
                    res.switched      = 1'b1;
                    link_wdata        = cur_task_reg;
                    link_we           = cur_valid_reg && q_ne;
                end
            end
            ST_NOP:
            begin
                res_valid = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            id_reg          <= '0;
            pri_reg         <= '0;
            was_running_reg <= 1'b0;
            pop_q_reg       <= '0;
            pop_task_reg    <= '0;
            nonempty_reg    <= '0;
            live_reg        <= '0;
            cur_task_reg    <= '0;
            cur_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        id_reg          <= task_id;
                        pri_reg         <= priority_req;
                        was_running_reg <= (action == ACT_FINISH) && cur_valid_reg;
                        // A finish retires the running task before the yield part.
                        if ((action == ACT_FINISH) && cur_valid_reg)
                        begin
                            live_reg[cur_task_reg] <= 1'b0;
                            cur_valid_reg          <= 1'b0;
                            cur_task_reg           <= '0;
                        end
                    end
                end
                ST_CREATE:
                begin
                    if (out_free && create_ok)
                    begin
                        live_reg[id_idx] <= 1'b1;
                        tail_reg[q_idx]  <= id_idx;
                        if (!q_ne)
                        begin
                            head_reg[q_idx]     <= id_idx;
                            nonempty_reg[q_idx] <= 1'b1;
                        end
                    end
                end
                ST_POP:
                begin
                    if (any_ready)
                    begin
                        pop_q_reg    <= enc_q;
                        pop_task_reg <= q_head;
                        if (q_head == q_tail)
                        begin
                            nonempty_reg[q_idx] <= 1'b0;
                        end
                    end
                end
                ST_LINK:
                begin
                    head_reg[pop_q_reg] <= link_rdata;
                end
                ST_REQUEUE:
                begin
                    if (out_free)
                    begin
                        // The preempted task goes back at its own priority.
                        if (cur_valid_reg)
                        begin
                            tail_reg[q_idx] <= cur_task_reg;
                            if (!q_ne)
                            begin
                                head_reg[q_idx]     <= cur_task_reg;
                                nonempty_reg[q_idx] <= 1'b1;
                            end
                        end
                        cur_task_reg  <= pop_task_reg;
                        cur_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_res_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result issued while the output register is occupied");

    a_running_is_live: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> live_reg[cur_task_reg])
        else $error("running task is not marked live");

    a_link_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LINK |-> $past(state_reg) == ST_POP)
        else $error("link fetch state entered without a pop");

    a_switch_runs_task: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REQUEUE && out_free |=> cur_valid_reg)
        else $error("switch completed without a running task");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && in_valid && action == ACT_FINISH |=> !cur_valid_reg)
        else $error("finish did not retire the running task");
`endif

endmodule

// File: src/priority_ready_queue_scheduler.sv
// Priority ready queue scheduler: handshake front end and result register.
// Depends on prqs_pkg and prqs_core (which holds the link and priority memories).
//
// Usage: the input channel (in_valid/in_ready) carries one scheduling event per
// beat: action (create, yield, finish), task_id and priority_req. The output
// channel (out_valid/out_ready) returns exactly one beat per event with the
// running task, whether a task runs, whether it changed, and a create status.
// in_ready is high only while the sequencer is idle; one event is processed at
// a time. Create, unknown actions and a yield or finish that finds every queue
// empty pass through the create, no-op or pop state and return to idle; a yield
// or finish that takes a ready task passes through pop and requeue, with a link
// fetch state between them when the popped queue holds more than one task,
// because the new queue head comes from the link memory's registered read port.
// The result enters the output register at the edge the block is ready again.
// Reset clears all queues, all live bits and the running task (idle). If the
// receiver stalls, the result waits in the output register; the next event is
// still accepted and processed up to its result, which then waits for the
// register to empty.
module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int NUM_TASKS      = PRQS_NUM_TASKS,
    parameter int NUM_PRIORITIES = PRQS_NUM_PRIORITIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ACTION_W-1:0]   action,
    input  logic [TASK_ID_W-1:0]  task_id,
    input  logic [PRIORITY_W-1:0] priority_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TASK_ID_W-1:0]  active_task,
    output logic                  running_valid,
    output logic                  switched,
    output logic                  status
);

    logic      out_valid_reg;
    prqs_res_t out_res_reg;
    logic      out_free;
    logic      res_valid;
    prqs_res_t res;

    assign out_free = !out_valid_reg || out_ready;

    prqs_core #(
        .NUM_TASKS      (NUM_TASKS),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .task_id      (task_id),
        .priority_req (priority_req),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign active_task   = out_res_reg.active_task;
    assign running_valid = out_res_reg.running_valid;
    assign switched      = out_res_reg.switched;
    assign status        = out_res_reg.status;

endmodule

// File: dv/prqs_sched_checker.sv
// Scoreboard for the priority ready queue scheduler: predicts every result beat
// from the accepted event beats and compares them field by field.
// Depends on prqs_pkg only.
module prqs_sched_checker
    import prqs_pkg::*;
#(
    parameter int NUM_TASKS      = PRQS_NUM_TASKS,
    parameter int NUM_PRIORITIES = PRQS_NUM_PRIORITIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [ACTION_W-1:0]   action,
    input  logic [TASK_ID_W-1:0]  task_id,
    input  logic [PRIORITY_W-1:0] priority_req,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [TASK_ID_W-1:0]  active_task,
    input  logic                  running_valid,
    input  logic                  switched,
    input  logic                  status,
    output int                    mismatch_count,
    output int                    results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the ready queues, the task table and the running task.
    logic [TASK_ID_W-1:0]  rq_head   [NUM_PRIORITIES];
    logic [TASK_ID_W-1:0]  rq_tail   [NUM_PRIORITIES];
    bit                    rq_filled [NUM_PRIORITIES];
    logic [TASK_ID_W-1:0]  link_of   [NUM_TASKS];
    logic [PRIORITY_W-1:0] prio_of   [NUM_TASKS];
    bit                    is_live   [NUM_TASKS];
    logic [TASK_ID_W-1:0]  cur_task;
    bit                    cur_on;

    prqs_res_t expected_q[$];

    function automatic void clear_sched();
        for (int p = 0; p < NUM_PRIORITIES; p++)
        begin
            rq_head[p]   = '0;
            rq_tail[p]   = '0;
            rq_filled[p] = 1'b0;
        end
        for (int t = 0; t < NUM_TASKS; t++)
        begin
            link_of[t] = '0;
            prio_of[t] = '0;
            is_live[t] = 1'b0;
        end
        cur_task = '0;
        cur_on   = 1'b0;
    endfunction

    function automatic void append_ready(int p, logic [TASK_ID_W-1:0] t);
        if (rq_filled[p])
        begin
            link_of[rq_tail[p]] = t;
            rq_tail[p] = t;
        end
        else
        begin
            rq_head[p]   = t;
            rq_tail[p]   = t;
            rq_filled[p] = 1'b1;
        end
    endfunction

    // Takes the head of the most urgent non-empty queue.
    function automatic bit take_best(output logic [TASK_ID_W-1:0] t);
        bit found;
        found = 1'b0;
        t = '0;
        for (int p = 0; p < NUM_PRIORITIES && !found; p++)
        begin
            if (rq_filled[p])
            begin
                t = rq_head[p];
                if (rq_head[p] == rq_tail[p])
                    rq_filled[p] = 1'b0;
                else
                    rq_head[p] = link_of[rq_head[p]];
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // The preempted task goes back at its own priority.
    function automatic bit switch_to_next();
        logic [TASK_ID_W-1:0] t;
        if (!take_best(t))
            return 1'b0;
        if (cur_on)
            append_ready(prio_of[cur_task], cur_task);
        cur_task = t;
        cur_on   = 1'b1;
        return 1'b1;
    endfunction

    function automatic prqs_res_t schedule_event(logic [ACTION_W-1:0] act,
                                                 logic [TASK_ID_W-1:0] id,
                                                 logic [PRIORITY_W-1:0] pri);
        prqs_res_t r;
        bit        was_on;
        bit        took;
        int        level;
        r = '0;
        r.status = STATUS_OK;
        case (act)
            ACT_CREATE:
            begin
                if (id >= NUM_TASKS || is_live[id])
                    r.status = STATUS_REFUSED;
                else
                begin
                    level = (pri >= NUM_PRIORITIES) ? NUM_PRIORITIES - 1 : pri;
                    is_live[id] = 1'b1;
                    prio_of[id] = PRIORITY_W'(level);
                    append_ready(level, id);
                end
            end
            ACT_YIELD:
                r.switched = switch_to_next();
            ACT_FINISH:
            begin
                was_on = cur_on;
                if (cur_on)
                begin
                    is_live[cur_task] = 1'b0;
                    cur_on   = 1'b0;
                    cur_task = '0;
                end
                took = switch_to_next();
                r.switched = took | was_on;
            end
            default: ;
        endcase
        r.active_task   = cur_on ? cur_task : '0;
        r.running_valid = cur_on;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        prqs_res_t want;
        if (!rst_n)
        begin
            clear_sched();
            expected_q.delete();
            mismatch_count = 0;
            results_owed <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(schedule_event(action, task_id, priority_req));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with none expected, expected none, %s %0h/%0b/%0b/%0b",
                             $time, "actual", active_task, running_valid, switched, status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("active_task", 8'(want.active_task), 8'(active_task));
                    check_field("running_valid", 8'(want.running_valid), 8'(running_valid));
                    check_field("switched", 8'(want.switched), 8'(switched));
                    check_field("status", 8'(want.status), 8'(status));
                end
            end
            results_owed <= expected_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Top of the scheduler testbench: clock, reset, event stimulus, result stalls
// and the verdict. Depends on prqs_pkg, prqs_sched_checker and the scheduler RTL.
module tb_top;
    import prqs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int BEATS_PER_PHASE = 315;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ACTION_W-1:0]   action = ACT_CREATE;
    logic [TASK_ID_W-1:0]  task_id = '0;
    logic [PRIORITY_W-1:0] priority_req = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [TASK_ID_W-1:0]  active_task;
    logic                  running_valid;
    logic                  switched;
    logic                  status;
    int                    mismatch_count;
    int                    results_owed;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          cycle_count = 0;

    priority_ready_queue_scheduler u_top (.*);
    prqs_sched_checker u_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_event(logic [ACTION_W-1:0] act, logic [TASK_ID_W-1:0] id,
                              logic [PRIORITY_W-1:0] pri);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        task_id      <= id;
        priority_req <= pri;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Mostly creates, yields and finishes so the queues fill and drain.
    task automatic send_random_event();
        int unsigned pick;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < 40)
            act = ACT_CREATE;
        else if (pick < 70)
            act = ACT_YIELD;
        else if (pick < 94)
            act = ACT_FINISH;
        else
            act = ACT_UNUSED;
        send_event(act, TASK_ID_W'($urandom_range(15)), PRIORITY_W'($urandom_range(3)));
    endtask

    initial
    begin
        int unsigned idle_by_phase[4]  = '{0, 72, 0, 20};
        int unsigned stall_by_phase[4] = '{0, 0, 72, 20};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: idle corner cases, extremes of the fields,
        // a refused create, requeue at the preempted task's own priority,
        // finishing into idle and reuse of a retired slot.
        send_event(ACT_YIELD, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd15, 2'd3);
        send_event(ACT_UNUSED, 4'd15, 2'd3);
        send_event(ACT_CREATE, 4'd0, 2'd0);
        send_event(ACT_CREATE, 4'd15, 2'd3);
        send_event(ACT_CREATE, 4'd15, 2'd0);
        send_event(ACT_CREATE, 4'd5, 2'd3);
        send_event(ACT_CREATE, 4'd9, 2'd1);
        send_event(ACT_CREATE, 4'd10, 2'd2);
        send_event(ACT_YIELD, 4'd15, 2'd3);
        send_event(ACT_CREATE, 4'd3, 2'd1);
        send_event(ACT_YIELD, 4'd0, 2'd0);
        send_event(ACT_YIELD, 4'd0, 2'd0);
        send_event(ACT_UNUSED, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_YIELD, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_FINISH, 4'd0, 2'd0);
        send_event(ACT_CREATE, 4'd0, 2'd2);
        send_event(ACT_YIELD, 4'd0, 2'd0);
        send_event(ACT_YIELD, 4'd0, 2'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            repeat (BEATS_PER_PHASE) send_random_event();
        end

        in_valid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
